// ===== rtl/ctne_pkg.sv =====
// Shared types, codes and character-class helpers for the tag name encoder.
// No dependencies; every other file but ctne_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ctne_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       closing;
    logic [1:0] status;
  } out_item_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_LONG   = 2'd2;
  localparam logic [1:0] ST_WORDS  = 2'd3;

  localparam logic [7:0] SEG_SYMBOL = 8'h91;
  localparam logic [7:0] SEG_ELEM8  = 8'h28;
  localparam logic [7:0] SEG_ELEM16 = 8'h29;
  localparam logic [7:0] SEG_ELEM32 = 8'h2A;

  typedef enum logic [3:0] {
    M_IDLE, M_NAME, M_LEAD, M_SIGN, M_ZERO, M_OCT, M_DEC, M_HEX, M_TAIL
  } mode_t;

  typedef enum logic [2:0] {
    SRC_HDR, SRC_LEN, SRC_RAM, SRC_PAD, SRC_NUM, SRC_CLOSE, SRC_ERR
  } src_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_HDR, S_LEN, S_RD, S_CH, S_PAD, S_NUM, S_CLOSE, S_ERR
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic emit;
    src_t src;
    logic clr_idx;
    logic inc_idx;
    logic inc_k;
    logic clr_count;
    logic clear_str;
    logic set_latch;
  } cmd_t;

  typedef struct packed {
    logic       latched;
    logic       last;
    logic [1:0] err;
    logic       flush;
    logic       num;
    logic       out_free;
    logic       idx_last;
    logic       count_odd;
    logic       num_last;
  } stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_name_start(input logic [7:0] c);
    return is_alpha(c) || c == "_" || c == ":";
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_name_start(c) || is_digit(c);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_digit(c)) r = {1'b1, c[3:0]};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cip_tag_name_encoder.sv =====
// Tag name to path segment encoder: one character per item in, segment bytes out.
// An item is registered, then evaluated; the next is taken once its results are out.
// A number emits its segment bytes; a name emits its header, length, characters and
// a pad if odd, and the final character of a string adds the closing result.
// Results leave through one output register; a stall there holds the sequencer.
// Reset (rst, synchronous): parser returns to between-elements, counters clear;
// the name buffer is not cleared and is only read after being written.
`timescale 1ns / 1ps
`default_nettype none

module cip_tag_name_encoder
  import ctne_pkg::*;
#(
  parameter int MAX_NAME = 40
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  cmd_t  cmd;
  stat_t stat;

  ctne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctne_dp #(.MAX_NAME(MAX_NAME)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/ctne_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ctne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ctne_ctrl.sv =====
// Sequencer for the tag name encoder: evaluates one item, then walks the
// segment bytes out. Depends on ctne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctne_ctrl
  import ctne_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        priority if (stat.latched)    state_next = S_IDLE;
        else if (stat.err != ST_OK)   state_next = S_ERR;
        else if (stat.flush)          state_next = S_HDR;
        else if (stat.num)            state_next = S_NUM;
        else if (stat.last)           state_next = S_CLOSE;
        else                          state_next = S_IDLE;
      end
      S_HDR: if (stat.out_free) state_next = S_LEN;
      S_LEN: if (stat.out_free) state_next = S_RD;
      S_RD:  state_next = S_CH;
      S_CH: begin
        if (stat.out_free) begin
          if (!stat.idx_last)      state_next = S_RD;
          else if (stat.count_odd) state_next = S_PAD;
          else                     state_next = stat.last ? S_CLOSE : S_IDLE;
        end
      end
      S_PAD: if (stat.out_free) state_next = stat.last ? S_CLOSE : S_IDLE;
      S_NUM: begin
        if (stat.out_free && stat.num_last) state_next = stat.last ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: if (stat.out_free) state_next = S_IDLE;
      S_ERR:   if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.src = SRC_HDR;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: cmd.capture = in_valid;
      S_EVAL: begin
        cmd.eval = 1'b1;
        cmd.clear_str = stat.latched && stat.last;
      end
      S_HDR: begin
        cmd.emit = stat.out_free;
        cmd.src  = SRC_HDR;
      end
      S_LEN: begin
        cmd.emit    = stat.out_free;
        cmd.src     = SRC_LEN;
        cmd.clr_idx = 1'b1;
      end
      S_RD: cmd.src = SRC_RAM;
      S_CH: begin
        cmd.emit      = stat.out_free;
        cmd.src       = SRC_RAM;
        cmd.inc_idx   = stat.out_free && !stat.idx_last;
        cmd.clr_count = stat.out_free && stat.idx_last && !stat.count_odd;
      end
      S_PAD: begin
        cmd.emit      = stat.out_free;
        cmd.src       = SRC_PAD;
        cmd.clr_count = stat.out_free;
      end
      S_NUM: begin
        cmd.emit  = stat.out_free;
        cmd.src   = SRC_NUM;
        cmd.inc_k = stat.out_free;
      end
      S_CLOSE: begin
        cmd.emit      = stat.out_free;
        cmd.src       = SRC_CLOSE;
        cmd.clear_str = stat.out_free;
      end
      S_ERR: begin
        cmd.emit      = stat.out_free;
        cmd.src       = SRC_ERR;
        cmd.clear_str = stat.out_free && stat.last;
        cmd.set_latch = stat.out_free && !stat.last;
      end
      default: cmd = '0;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> in_stall) else $error("emit while accepting");
  a_eval_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> $past(in_valid && !in_stall)) else $error("eval without item");
  a_single_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_str, cmd.set_latch})) else $error("clear and latch together");

endmodule

`default_nettype wire

// ===== rtl/ctne_dp.sv =====
// Datapath of the tag name encoder: parse registers, name buffer, number
// accumulator, byte counter and output register. Depends on ctne_pkg, ctne_ram.
`timescale 1ns / 1ps
`default_nettype none

module ctne_dp
  import ctne_pkg::*;
#(
  parameter int MAX_NAME = 40
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_data,
  input  wire cmd_t      cmd,
  output stat_t          stat,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam int CW = $clog2(MAX_NAME + 1);

  logic [7:0]    ch;
  logic          last;
  mode_t         mode;
  logic [CW-1:0] count;
  logic [31:0]   index;
  logic          neg;
  logic          seen;
  logic [9:0]    bytes;
  logic          latched;
  logic [1:0]    err_code;
  logic [31:0]   num_v;
  logic [AW-1:0] idx;
  logic [2:0]    k;
  logic [7:0]    rd_data;

  // next-value logic for one character
  logic [1:0]    err;
  mode_t         nmode;
  logic          flush, num, wr;
  logic [AW-1:0] waddr;
  logic [CW-1:0] count_next;
  logic [31:0]   index_next;
  logic          neg_next, seen_next;
  logic          do_idle, do_first, do_after, enter_lead;
  logic [4:0]    hv;

  always_comb begin
    err = ST_OK; nmode = mode; flush = 1'b0; num = 1'b0; wr = 1'b0;
    waddr = count[AW-1:0]; count_next = count; index_next = index;
    neg_next = neg; seen_next = seen;
    do_idle = 1'b0; do_first = 1'b0; do_after = 1'b0; enter_lead = 1'b0;
    hv = hex_value(ch);
    unique case (mode)
      M_IDLE: do_idle = 1'b1;
      M_NAME: begin
        if (is_name_char(ch)) begin
          if (count >= CW'(MAX_NAME)) err = ST_LONG;
          else begin
            wr = 1'b1;
            count_next = count + CW'(1);
          end
        end else begin
          flush = 1'b1;
          nmode = M_IDLE;
          do_idle = 1'b1;
        end
      end
      M_LEAD: begin
        if (is_ws(ch)) begin
        end else if (ch == "+" || ch == "-") begin
          neg_next = (ch == "-");
          nmode = M_SIGN;
        end else do_first = 1'b1;
      end
      M_SIGN: do_first = 1'b1;
      M_ZERO: begin
        if (ch == "x" || ch == "X") begin
          nmode = M_HEX;
          seen_next = 1'b0;
        end else if (ch >= "0" && ch <= "7") begin
          nmode = M_OCT;
          index_next = {29'd0, ch[2:0]};
        end else do_after = 1'b1;
      end
      M_OCT: begin
        if (ch >= "0" && ch <= "7") index_next = {index[28:0], ch[2:0]};
        else do_after = 1'b1;
      end
      M_DEC: begin
        if (is_digit(ch))
          index_next = {index[28:0], 3'd0} + {index[30:0], 1'b0} + {28'd0, ch[3:0]};
        else do_after = 1'b1;
      end
      M_HEX: begin
        if (hv[4]) begin
          index_next = {index[27:0], hv[3:0]};
          seen_next = 1'b1;
        end else if (!seen) err = ST_SYNTAX;
        else do_after = 1'b1;
      end
      M_TAIL: begin
        if (is_ws(ch)) begin
        end else if (ch == ",") enter_lead = 1'b1;
        else if (ch == "]") nmode = M_IDLE;
        else err = ST_SYNTAX;
      end
      default: err = ST_SYNTAX;
    endcase

    if (do_idle) begin
      if (is_name_start(ch)) begin
        wr = 1'b1; waddr = '0; count_next = CW'(1); nmode = M_NAME;
      end else if (ch == "[") enter_lead = 1'b1;
      else if (ch != ".") err = ST_SYNTAX;
    end
    if (do_first) begin
      if (ch == "0") begin
        nmode = M_ZERO; index_next = '0;
      end else if (is_digit(ch)) begin
        nmode = M_DEC; index_next = {28'd0, ch[3:0]};
      end else err = ST_SYNTAX;
    end
    if (do_after) begin
      if (is_ws(ch)) begin
        num = 1'b1; nmode = M_TAIL;
      end else if (ch == ",") begin
        num = 1'b1; enter_lead = 1'b1;
      end else if (ch == "]") begin
        num = 1'b1; nmode = M_IDLE;
      end else err = ST_SYNTAX;
    end
    if (enter_lead) begin
      nmode = M_LEAD; index_next = '0; neg_next = 1'b0; seen_next = 1'b0;
    end
    if (err == ST_OK && last) begin
      if (nmode == M_NAME) begin
        flush = 1'b1;
        nmode = M_IDLE;
      end
      if (nmode != M_IDLE) err = ST_SYNTAX;
    end
  end

  logic apply;
  assign apply = cmd.eval && !latched && (err == ST_OK);

  ctne_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_name_ram (
    .clk   (clk),
    .we    (apply && wr),
    .waddr (waddr),
    .wdata (ch),
    .raddr (idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch   <= in_data.ch;
      last <= in_data.end_of_name;
    end
    if (cmd.eval) begin
      err_code <= err;
      num_v    <= neg ? (32'd0 - index) : index;
    end
    if (cmd.clr_idx)      idx <= '0;
    else if (cmd.inc_idx) idx <= idx + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_str) begin
      mode <= M_IDLE; count <= '0; index <= '0; neg <= 1'b0; seen <= 1'b0;
      bytes <= '0; latched <= 1'b0;
    end else begin
      if (apply) begin
        mode <= nmode; count <= count_next; index <= index_next;
        neg <= neg_next; seen <= seen_next;
      end
      if (cmd.clr_count) count <= '0;
      if (cmd.set_latch) latched <= 1'b1;
      // saturate the segment byte counter
      if (cmd.emit && cmd.src != SRC_CLOSE && cmd.src != SRC_ERR && bytes != 10'h3FF)
        bytes <= bytes + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.eval) k <= '0;
    else if (cmd.inc_k)  k <= k + 3'd1;
  end

  logic big, mid;
  logic [7:0] num_byte, sel_byte;
  assign big = |num_v[31:16];
  assign mid = |num_v[15:8];

  always_comb begin
    unique case (k)
      3'd0:    num_byte = big ? SEG_ELEM32 : (mid ? SEG_ELEM16 : SEG_ELEM8);
      3'd1:    num_byte = (big || mid) ? 8'd0 : num_v[7:0];
      3'd2:    num_byte = num_v[7:0];
      3'd3:    num_byte = num_v[15:8];
      3'd4:    num_byte = num_v[23:16];
      3'd5:    num_byte = num_v[31:24];
      default: num_byte = 8'd0;
    endcase
  end

  always_comb begin
    unique case (cmd.src)
      SRC_HDR:   sel_byte = SEG_SYMBOL;
      SRC_LEN:   sel_byte = 8'(count);
      SRC_RAM:   sel_byte = rd_data;
      SRC_NUM:   sel_byte = num_byte;
      SRC_CLOSE: sel_byte = bytes[9] ? 8'd0 : bytes[8:1];
      default:   sel_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.emit) begin
      out_data.out_byte <= sel_byte;
      out_data.closing  <= (cmd.src == SRC_CLOSE) || (cmd.src == SRC_ERR);
      out_data.status   <= (cmd.src == SRC_ERR) ? err_code :
                           (cmd.src == SRC_CLOSE && bytes[9]) ? ST_WORDS : ST_OK;
    end
  end

  assign stat.latched   = latched;
  assign stat.last      = last;
  assign stat.err       = err;
  assign stat.flush     = flush;
  assign stat.num       = num;
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.idx_last  = (CW'(idx) + CW'(1)) == count;
  assign stat.count_odd = count[0];
  assign stat.num_last  = big ? (k == 3'd5) : (mid ? (k == 3'd3) : (k == 3'd1));

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free) else $error("emit over a waiting item");
  a_status_closing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.closing) |-> (out_data.status == ST_OK))
    else $error("status on a segment byte");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_str |=> (bytes == 10'd0 && !latched)) else $error("string state not cleared");

endmodule

`default_nettype wire
